/* src/dnsap_pkg.sv */
// shared types and constants for the dns a-record response parser
package dnsap_pkg;

  // parse phase, one-hot
  typedef enum logic [11:0] {
    PH_HDR    = 12'b0000_0000_0001,
    PH_QNAME  = 12'b0000_0000_0010,
    PH_QPTR   = 12'b0000_0000_0100,
    PH_QTYPE  = 12'b0000_0000_1000,
    PH_QCLASS = 12'b0000_0001_0000,
    PH_ANAME  = 12'b0000_0010_0000,
    PH_APTR   = 12'b0000_0100_0000,
    PH_ATYPE  = 12'b0000_1000_0000,
    PH_ACLASS = 12'b0001_0000_0000,
    PH_TTL    = 12'b0010_0000_0000,
    PH_RDLEN  = 12'b0100_0000_0000,
    PH_RDATA  = 12'b1000_0000_0000
  } phase_t;

  // result kinds
  localparam logic [2:0] KIND_ADDRESS     = 3'd0;
  localparam logic [2:0] KIND_NO_ANSWERS  = 3'd1;
  localparam logic [2:0] KIND_QTYPE_BAD   = 3'd2;
  localparam logic [2:0] KIND_QCLASS_BAD  = 3'd3;
  localparam logic [2:0] KIND_TYPE_BAD    = 3'd4;
  localparam logic [2:0] KIND_CLASS_BAD   = 3'd5;
  localparam logic [2:0] KIND_RDLEN_BAD   = 3'd6;
  localparam logic [2:0] KIND_TRUNCATED   = 3'd7;

  // header and field constants
  localparam logic [3:0]  HDR_BYTES      = 4'd12;
  localparam logic [3:0]  HDR_RCODE_POS  = 4'd3;
  localparam logic [3:0]  HDR_QD_HI      = 4'd4;
  localparam logic [3:0]  HDR_QD_LO      = 4'd5;
  localparam logic [3:0]  HDR_AN_HI      = 4'd6;
  localparam logic [3:0]  HDR_AN_LO      = 4'd7;
  localparam logic [3:0]  PAIR_BYTES     = 4'd2;
  localparam logic [3:0]  QUAD_BYTES     = 4'd4;
  localparam logic [15:0] TYPE_A         = 16'd1;
  localparam logic [15:0] CLASS_IN       = 16'd1;
  localparam logic [15:0] RDLEN_IPV4     = 16'd4;
  localparam logic [1:0]  PTR_MARK       = 2'b11;

  typedef struct packed {
    phase_t      phase;
    logic [3:0]  field_byte_count;
    logic [7:0]  label_bytes_left;
    logic [15:0] question_count;
    logic [15:0] answers_left;
    logic [15:0] answer_index;
    logic [15:0] field_accumulator;
    logic [31:0] address_shift;
    logic [3:0]  rcode_hold;
    logic        packet_finished;
  } parse_state_t;

  localparam parse_state_t STATE_RESET = '{
    phase:             PH_HDR,
    field_byte_count:  4'd0,
    label_bytes_left:  8'd0,
    question_count:    16'd0,
    answers_left:      16'd0,
    answer_index:      16'd0,
    field_accumulator: 16'd0,
    address_shift:     32'd0,
    rcode_hold:        4'd0,
    packet_finished:   1'b0
  };

  typedef struct packed {
    logic        emit;
    logic [2:0]  kind;
    logic [31:0] addr;
    logic [15:0] num;
    logic [3:0]  rcode;
    logic        fin;
  } parse_result_t;

endpackage

/* src/dnsap_step.sv */
// next-state and result logic for one byte of the dns response
module dnsap_step import dnsap_pkg::*; (
  input  parse_state_t  cur,
  input  logic [7:0]    packet_byte,
  input  logic          end_of_packet,
  output parse_state_t  nxt,
  output parse_result_t res
);

  parse_state_t upd;
  logic [3:0]   cnt_inc;
  logic [15:0]  acc_shift;
  logic         pair_done;
  logic [31:0]  addr_shift;

  always_comb begin
    upd        = cur;
    res        = '0;
    res.kind   = KIND_ADDRESS;
    cnt_inc    = cur.field_byte_count + 4'd1;
    acc_shift  = {cur.field_accumulator[7:0], packet_byte};
    pair_done  = (cnt_inc >= PAIR_BYTES);
    addr_shift = {cur.address_shift[23:0], packet_byte};

    if (!cur.packet_finished) begin
      case (cur.phase)
        PH_HDR: begin
          if (cur.field_byte_count == HDR_RCODE_POS) begin
            upd.rcode_hold = packet_byte[3:0];
          end else if (cur.field_byte_count inside {HDR_QD_HI, HDR_QD_LO}) begin
            upd.question_count = {cur.question_count[7:0], packet_byte};
          end else if (cur.field_byte_count inside {HDR_AN_HI, HDR_AN_LO}) begin
            upd.answers_left = {cur.answers_left[7:0], packet_byte};
          end
          upd.field_byte_count = cnt_inc;
          if (cnt_inc >= HDR_BYTES) begin
            upd.field_byte_count = 4'd0;
            if (upd.question_count != 16'd0) begin
              upd.phase = PH_QNAME;
            end else if (upd.answers_left != 16'd0) begin
              upd.phase = PH_ANAME;
            end else begin
              res.emit = 1'b1;
              res.kind = KIND_NO_ANSWERS;
              res.fin  = 1'b1;
            end
          end
        end
        PH_QNAME, PH_ANAME: begin
          if (cur.label_bytes_left != 8'd0) begin
            upd.label_bytes_left = cur.label_bytes_left - 8'd1;
          end else if (packet_byte == 8'd0) begin
            upd.phase = (cur.phase == PH_QNAME) ? PH_QTYPE : PH_ATYPE;
          end else if (packet_byte[7:6] == PTR_MARK) begin
            upd.phase = (cur.phase == PH_QNAME) ? PH_QPTR : PH_APTR;
          end else begin
            upd.label_bytes_left = packet_byte;
          end
        end
        PH_QPTR: upd.phase = PH_QTYPE;
        PH_APTR: upd.phase = PH_ATYPE;
        PH_QTYPE, PH_QCLASS, PH_ATYPE, PH_ACLASS, PH_RDLEN: begin
          upd.field_accumulator = acc_shift;
          upd.field_byte_count  = cnt_inc;
          if (pair_done) begin
            upd.field_byte_count  = 4'd0;
            upd.field_accumulator = 16'd0;
            case (cur.phase)
              PH_QTYPE: begin
                if (acc_shift != TYPE_A) begin
                  res.emit = 1'b1; res.kind = KIND_QTYPE_BAD; res.fin = 1'b1;
                end else begin
                  upd.phase = PH_QCLASS;
                end
              end
              PH_QCLASS: begin
                if (acc_shift != CLASS_IN) begin
                  res.emit = 1'b1; res.kind = KIND_QCLASS_BAD; res.fin = 1'b1;
                end else if (cur.answers_left == 16'd0) begin
                  res.emit = 1'b1; res.kind = KIND_NO_ANSWERS; res.fin = 1'b1;
                end else begin
                  upd.phase = PH_ANAME;
                end
              end
              PH_ATYPE: begin
                if (acc_shift != TYPE_A) begin
                  res.emit = 1'b1; res.kind = KIND_TYPE_BAD; res.fin = 1'b1;
                  res.num  = cur.answer_index;
                end else begin
                  upd.phase = PH_ACLASS;
                end
              end
              PH_ACLASS: begin
                if (acc_shift != CLASS_IN) begin
                  res.emit = 1'b1; res.kind = KIND_CLASS_BAD; res.fin = 1'b1;
                  res.num  = cur.answer_index;
                end else begin
                  upd.phase = PH_TTL;
                end
              end
              default: begin
                if (acc_shift != RDLEN_IPV4) begin
                  res.emit = 1'b1; res.kind = KIND_RDLEN_BAD; res.fin = 1'b1;
                  res.num  = cur.answer_index;
                end else begin
                  upd.phase = PH_RDATA;
                end
              end
            endcase
          end
        end
        PH_TTL: begin
          upd.field_byte_count = cnt_inc;
          if (cnt_inc >= QUAD_BYTES) begin
            upd.field_byte_count = 4'd0;
            upd.phase            = PH_RDLEN;
          end
        end
        PH_RDATA: begin
          upd.address_shift    = addr_shift;
          upd.field_byte_count = cnt_inc;
          if (cnt_inc >= QUAD_BYTES) begin
            upd.field_byte_count = 4'd0;
            res.emit             = 1'b1;
            res.kind             = KIND_ADDRESS;
            res.addr             = addr_shift;
            res.num              = cur.answer_index;
            res.fin              = (cur.answers_left <= 16'd1);
            upd.address_shift    = 32'd0;
            upd.answers_left     = cur.answers_left - 16'd1;
            upd.answer_index     = cur.answer_index + 16'd1;
            upd.phase            = PH_ANAME;
          end
        end
        default: upd.phase = PH_HDR;
      endcase
      if (res.fin) begin
        upd.packet_finished = 1'b1;
      end
    end

    // premature end replaces whatever this byte produced
    if (end_of_packet && !upd.packet_finished) begin
      res.emit = 1'b1;
      res.kind = KIND_TRUNCATED;
      res.addr = 32'd0;
      res.num  = upd.answer_index;
      res.fin  = 1'b1;
    end
    res.rcode = upd.rcode_hold;

    nxt = end_of_packet ? STATE_RESET : upd;
  end

endmodule

/* src/dns_a_record_response_parser_top.sv */
// top level of the dns a-record response parser
//
// input channel: one message byte per word (packet_byte) with end_of_packet
//   on the last byte, taken when byte_valid and byte_ready are both high
// output channel: one result word (result_kind, ipv4_address, answer_number,
//   response_code, final_result), taken when result_valid and result_ready
//   are both high
// each byte is parsed in the cycle it is accepted; its result, if any, sits in
//   the result register from the next cycle
// throughput is one byte per cycle: byte_ready stays high while the result
//   register is empty or being taken in the same cycle
// a stalled receiver holds the result register; byte_ready then drops until
//   the word is taken, and the parser state waits with it
// bytes after a final result are swallowed up to end_of_packet; every
//   end_of_packet byte returns the parser to the header phase
// reset (synchronous, active high) returns the parser to the header phase and
//   empties the result register
module dns_a_record_response_parser_top import dnsap_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        byte_valid,
  output logic        byte_ready,
  input  logic [7:0]  packet_byte,
  input  logic        end_of_packet,
  output logic        result_valid,
  input  logic        result_ready,
  output logic [2:0]  result_kind,
  output logic [31:0] ipv4_address,
  output logic [15:0] answer_number,
  output logic [3:0]  response_code,
  output logic        final_result
);

  parse_state_t  state;
  parse_state_t  state_next;
  parse_result_t step_res;
  logic          accept;

  // the output register parts the two sides; drain and refill in the same cycle
  assign byte_ready = !result_valid || result_ready;
  assign accept     = byte_valid && byte_ready;

  dnsap_step u_step (
    .cur           (state),
    .packet_byte   (packet_byte),
    .end_of_packet (end_of_packet),
    .nxt           (state_next),
    .res           (step_res)
  );

  // parser state and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= STATE_RESET;
      result_valid <= 1'b0;
    end else begin
      if (accept) begin
        state        <= state_next;
        result_valid <= step_res.emit;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  // result payload, loaded only with a new word
  always_ff @(posedge clk) begin
    if (accept && step_res.emit) begin
      result_kind   <= step_res.kind;
      ipv4_address  <= step_res.addr;
      answer_number <= step_res.num;
      response_code <= step_res.rcode;
      final_result  <= step_res.fin;
    end
  end

endmodule

/* src/dnsap_checker.sv */
// port-level checks for the dns a-record response parser, bound to the top level
module dnsap_checker import dnsap_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        result_valid,
  input logic        result_ready,
  input logic [2:0]  result_kind,
  input logic [31:0] ipv4_address,
  input logic [15:0] answer_number,
  input logic        final_result
);

  // no word right after a reset cycle
  a_idle_after_reset: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result word right after reset");

  // a stalled word holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result_kind) &&
      $stable(ipv4_address) && $stable(answer_number) && $stable(final_result))
    else $error("stalled result word changed");

  // only address words carry an address
  a_addr_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_kind != KIND_ADDRESS |-> ipv4_address == 32'd0)
    else $error("non-address word with an address");

  // every status or error word ends the packet
  a_status_final: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_kind != KIND_ADDRESS |-> final_result)
    else $error("status word not final");

  // question-level words name no answer
  a_question_num: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result_kind == KIND_NO_ANSWERS || result_kind == KIND_QTYPE_BAD ||
      result_kind == KIND_QCLASS_BAD) |-> answer_number == 16'd0)
    else $error("question-level word with an answer number");

endmodule

bind dns_a_record_response_parser_top dnsap_checker u_dnsap_checker (
  .clk           (clk),
  .rst           (rst),
  .result_valid  (result_valid),
  .result_ready  (result_ready),
  .result_kind   (result_kind),
  .ipv4_address  (ipv4_address),
  .answer_number (answer_number),
  .final_result  (final_result)
);

/* verif/dns_a_record_response_parser_top_tb.sv */
// testbench for the dns a-record response parser: directed and random responses checked against an in-bench parser
`timescale 1ns / 1ps

module dns_a_record_response_parser_top_tb;
  import dnsap_pkg::*;

  localparam int STALL_LIMIT = 5000;
  localparam int MAX_PRINTED = 40;

  // ways a built response can be damaged on purpose
  typedef enum int {
    FLAW_NONE,
    FLAW_QTYPE,
    FLAW_QCLASS,
    FLAW_ATYPE,
    FLAW_ACLASS,
    FLAW_RDLEN
  } flaw_t;

  // one result word as seen on the output channel
  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] addr;
    logic [15:0] num;
    logic [3:0]  rcode;
    logic        fin;
  } dns_word_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        byte_valid = 1'b0;
  logic        byte_ready;
  logic [7:0]  packet_byte = 8'h00;
  logic        end_of_packet = 1'b0;
  logic        result_valid;
  logic        result_ready = 1'b0;
  logic [2:0]  result_kind;
  logic [31:0] ipv4_address;
  logic [15:0] answer_number;
  logic [3:0]  response_code;
  logic        final_result;

  dns_a_record_response_parser_top dut (
    .clk           (clk),
    .rst           (rst),
    .byte_valid    (byte_valid),
    .byte_ready    (byte_ready),
    .packet_byte   (packet_byte),
    .end_of_packet (end_of_packet),
    .result_valid  (result_valid),
    .result_ready  (result_ready),
    .result_kind   (result_kind),
    .ipv4_address  (ipv4_address),
    .answer_number (answer_number),
    .response_code (response_code),
    .final_result  (final_result)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // idle odds in percent for each side
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  int mismatch_count = 0;
  int bytes_sent = 0;
  int packets_sent = 0;
  int words_checked = 0;
  int idle_cycles = 0;
  int long_label_len = 0;

  dns_word_t   expected_words[$];
  logic [7:0]  pkt_bytes[$];

  // parser mirror state
  phase_t      pred_phase;
  logic [3:0]  pred_count;
  logic [7:0]  pred_label_left;
  logic [15:0] pred_qdcount;
  logic [15:0] pred_answers_left;
  logic [15:0] pred_answer_idx;
  logic [15:0] pred_field;
  logic [31:0] pred_addr;
  logic [3:0]  pred_rcode;
  logic        pred_done;

  function automatic void clear_parse_state();
    pred_phase        = PH_HDR;
    pred_count        = '0;
    pred_label_left   = '0;
    pred_qdcount      = '0;
    pred_answers_left = '0;
    pred_answer_idx   = '0;
    pred_field        = '0;
    pred_addr         = '0;
    pred_rcode        = '0;
    pred_done         = 1'b0;
  endfunction

  // shifts one byte into a two-byte field, high when the pair is complete
  function automatic logic take_pair_byte(input logic [7:0] b);
    pred_field = {pred_field[7:0], b};
    pred_count = pred_count + 4'd1;
    if (pred_count >= PAIR_BYTES) begin
      pred_count = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // advances the mirror by one accepted byte and queues the word it causes
  function automatic void parse_byte(input logic [7:0] b, input logic eop);
    dns_word_t w;
    logic      emit;
    w    = '0;
    emit = 1'b0;
    if (!pred_done) begin
      case (pred_phase)
        PH_HDR: begin
          if (pred_count == HDR_RCODE_POS)
            pred_rcode = b[3:0];
          else if (pred_count == HDR_QD_HI || pred_count == HDR_QD_LO)
            pred_qdcount = {pred_qdcount[7:0], b};
          else if (pred_count == HDR_AN_HI || pred_count == HDR_AN_LO)
            pred_answers_left = {pred_answers_left[7:0], b};
          pred_count = pred_count + 4'd1;
          if (pred_count >= HDR_BYTES) begin
            pred_count = '0;
            if (pred_qdcount != 0)
              pred_phase = PH_QNAME;
            else if (pred_answers_left != 0)
              pred_phase = PH_ANAME;
            else begin
              emit = 1'b1; w.kind = KIND_NO_ANSWERS; w.fin = 1'b1;
            end
          end
        end
        PH_QNAME, PH_ANAME: begin
          if (pred_label_left != 0)
            pred_label_left = pred_label_left - 8'd1;
          else if (b == 8'h00)
            pred_phase = (pred_phase == PH_QNAME) ? PH_QTYPE : PH_ATYPE;
          else if (b[7:6] == PTR_MARK)
            pred_phase = (pred_phase == PH_QNAME) ? PH_QPTR : PH_APTR;
          else
            pred_label_left = b;
        end
        PH_QPTR: pred_phase = PH_QTYPE;
        PH_APTR: pred_phase = PH_ATYPE;
        PH_QTYPE: begin
          if (take_pair_byte(b)) begin
            if (pred_field != TYPE_A) begin
              emit = 1'b1; w.kind = KIND_QTYPE_BAD; w.fin = 1'b1;
            end else
              pred_phase = PH_QCLASS;
            pred_field = '0;
          end
        end
        PH_QCLASS: begin
          if (take_pair_byte(b)) begin
            if (pred_field != CLASS_IN) begin
              emit = 1'b1; w.kind = KIND_QCLASS_BAD; w.fin = 1'b1;
            end else if (pred_answers_left == 0) begin
              emit = 1'b1; w.kind = KIND_NO_ANSWERS; w.fin = 1'b1;
            end else
              pred_phase = PH_ANAME;
            pred_field = '0;
          end
        end
        PH_ATYPE: begin
          if (take_pair_byte(b)) begin
            if (pred_field != TYPE_A) begin
              emit = 1'b1; w.kind = KIND_TYPE_BAD; w.fin = 1'b1; w.num = pred_answer_idx;
            end else
              pred_phase = PH_ACLASS;
            pred_field = '0;
          end
        end
        PH_ACLASS: begin
          if (take_pair_byte(b)) begin
            if (pred_field != CLASS_IN) begin
              emit = 1'b1; w.kind = KIND_CLASS_BAD; w.fin = 1'b1; w.num = pred_answer_idx;
            end else
              pred_phase = PH_TTL;
            pred_field = '0;
          end
        end
        PH_TTL: begin
          pred_count = pred_count + 4'd1;
          if (pred_count >= QUAD_BYTES) begin
            pred_count = '0;
            pred_phase = PH_RDLEN;
          end
        end
        PH_RDLEN: begin
          if (take_pair_byte(b)) begin
            if (pred_field != RDLEN_IPV4) begin
              emit = 1'b1; w.kind = KIND_RDLEN_BAD; w.fin = 1'b1; w.num = pred_answer_idx;
            end else
              pred_phase = PH_RDATA;
            pred_field = '0;
          end
        end
        PH_RDATA: begin
          pred_addr  = {pred_addr[23:0], b};
          pred_count = pred_count + 4'd1;
          if (pred_count >= QUAD_BYTES) begin
            pred_count = '0;
            emit   = 1'b1;
            w.kind = KIND_ADDRESS;
            w.addr = pred_addr;
            w.num  = pred_answer_idx;
            w.fin  = (pred_answers_left <= 16'd1);
            pred_addr         = '0;
            pred_answers_left = pred_answers_left - 16'd1;
            pred_answer_idx   = pred_answer_idx + 16'd1;
            pred_phase        = PH_ANAME;
          end
        end
        default: pred_phase = PH_HDR;
      endcase
      if (emit && w.fin)
        pred_done = 1'b1;
    end
    // end of message before a final word: truncated status takes the slot
    if (eop && !pred_done) begin
      emit   = 1'b1;
      w.kind = KIND_TRUNCATED;
      w.addr = '0;
      w.num  = pred_answer_idx;
      w.fin  = 1'b1;
    end
    w.rcode = pred_rcode;
    if (emit)
      expected_words.push_back(w);
    if (eop)
      clear_parse_state();
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTED)
      $display("%0t: mismatch on %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
  endtask

  // receiver: random stalls at the current odds
  always @(posedge clk) begin
    if (rst)
      result_ready <= 1'b0;
    else
      result_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // each taken result word is compared with the oldest expectation
  always @(posedge clk) begin : check_words
    dns_word_t want;
    if (!rst && result_valid && result_ready) begin
      words_checked++;
      if (expected_words.size() == 0)
        report_mismatch("unexpected result word, kind", 32'(result_kind), 32'd0);
      else begin
        want = expected_words.pop_front();
        if (result_kind !== want.kind)
          report_mismatch("result_kind", 32'(result_kind), 32'(want.kind));
        if (ipv4_address !== want.addr)
          report_mismatch("ipv4_address", ipv4_address, want.addr);
        if (answer_number !== want.num)
          report_mismatch("answer_number", 32'(answer_number), 32'(want.num));
        if (response_code !== want.rcode)
          report_mismatch("response_code", 32'(response_code), 32'(want.rcode));
        if (final_result !== want.fin)
          report_mismatch("final_result", 32'(final_result), 32'(want.fin));
      end
    end
  end

  // watchdog: cycles with no word moving on either side
  always @(posedge clk) begin
    if (rst || (byte_valid && byte_ready) || (result_valid && result_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("watchdog: nothing accepted for %0d cycles, %0d words still due",
               idle_cycles, expected_words.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // sends one byte, holding valid and payload until taken; valid stays up after
  task automatic send_byte(input logic [7:0] b, input logic eop);
    while ($urandom_range(99) < send_idle_pct) begin
      byte_valid <= 1'b0;
      @(posedge clk);
    end
    byte_valid    <= 1'b1;
    packet_byte   <= b;
    end_of_packet <= eop;
    do
      @(posedge clk);
    while (!byte_ready);
    parse_byte(b, eop);
    bytes_sent++;
  endtask

  task automatic send_packet();
    for (int i = 0; i < pkt_bytes.size(); i++)
      send_byte(pkt_bytes[i], i == pkt_bytes.size() - 1);
    packets_sent++;
  endtask

  // lowers valid and waits until every due word has come out
  task automatic wait_results_drained();
    byte_valid <= 1'b0;
    do
      @(posedge clk);
    while (expected_words.size() != 0);
  endtask

  task automatic add_word16(input logic [15:0] v);
    pkt_bytes.push_back(v[15:8]);
    pkt_bytes.push_back(v[7:0]);
  endtask

  task automatic add_random_bytes(input int count);
    repeat (count) pkt_bytes.push_back(8'($urandom_range(255)));
  endtask

  // a name: up to two labels, then a zero byte or a compression pointer;
  // a requested long label goes into the next name only
  task automatic add_name();
    int n_labels;
    int len;
    n_labels = $urandom_range(2);
    for (int i = 0; i < n_labels; i++) begin
      if (i == 0 && long_label_len != 0)
        len = long_label_len;
      else if ($urandom_range(29) == 0)
        len = $urandom_range(191, 64);
      else
        len = $urandom_range(6, 1);
      pkt_bytes.push_back(8'(len));
      add_random_bytes(len);
    end
    if (long_label_len != 0 && n_labels == 0) begin
      pkt_bytes.push_back(8'(long_label_len));
      add_random_bytes(long_label_len);
    end
    long_label_len = 0;
    if ($urandom_range(1)) begin
      pkt_bytes.push_back({PTR_MARK, 6'($urandom_range(63))});
      pkt_bytes.push_back(8'($urandom_range(255)));
    end else
      pkt_bytes.push_back(8'h00);
  endtask

  // a wrong value: either one flipped bit or anything else
  function automatic logic [15:0] field_value(input logic [15:0] good, input logic corrupt);
    logic [15:0] v;
    if (!corrupt)
      return good;
    if ($urandom_range(1))
      return good ^ (16'd1 << $urandom_range(15));
    do
      v = 16'($urandom);
    while (v == good);
    return v;
  endfunction

  task automatic build_response(input logic [15:0] qd, input logic [15:0] an_hdr,
                                input int n_ans, input logic [3:0] rcode,
                                input flaw_t flaw, input int flaw_ans);
    pkt_bytes.delete();
    add_random_bytes(3);
    pkt_bytes.push_back({4'($urandom_range(15)), rcode});
    add_word16(qd);
    add_word16(an_hdr);
    add_random_bytes(4);
    if (qd != 0) begin
      add_name();
      add_word16(field_value(TYPE_A, flaw == FLAW_QTYPE));
      add_word16(field_value(CLASS_IN, flaw == FLAW_QCLASS));
    end
    for (int i = 0; i < n_ans; i++) begin
      add_name();
      add_word16(field_value(TYPE_A, flaw == FLAW_ATYPE && i == flaw_ans));
      add_word16(field_value(CLASS_IN, flaw == FLAW_ACLASS && i == flaw_ans));
      add_random_bytes(4);
      add_word16(field_value(RDLEN_IPV4, flaw == FLAW_RDLEN && i == flaw_ans));
      add_random_bytes(4);
    end
  endtask

  // header alone says nothing to do; also nothing after the question
  task automatic test_no_answers();
    build_response(16'd0, 16'd0, 0, 4'd0, FLAW_NONE, 0);
    send_packet();
    build_response(16'd1, 16'd0, 0, 4'hF, FLAW_NONE, 0);
    add_random_bytes(3);
    send_packet();
  endtask

  // address extremes, answers without a question
  task automatic test_address_extremes();
    build_response(16'd1, 16'd1, 1, 4'hF, FLAW_NONE, 0);
    for (int k = 1; k <= 4; k++)
      pkt_bytes[pkt_bytes.size() - k] = 8'hFF;
    send_packet();
    build_response(16'd0, 16'd2, 2, 4'h5, FLAW_NONE, 0);
    for (int k = 1; k <= 4; k++)
      pkt_bytes[pkt_bytes.size() - k] = 8'h00;
    send_packet();
  endtask

  // each type, class and rdlength check failing, with a full drain after the answer-class case
  task automatic test_field_checks();
    for (int f = FLAW_QTYPE; f <= FLAW_RDLEN; f++) begin
      build_response(16'd1, 16'd2, (f < FLAW_ATYPE) ? 0 : 2, 4'($urandom_range(15)),
                     flaw_t'(f), 1);
      send_packet();
      if (f == FLAW_ACLASS)
        wait_results_drained();
    end
  endtask

  // long labels whose length byte has top bits 01 or 10, and a header question count of 0xFFFF
  task automatic test_name_forms();
    long_label_len = 64;
    build_response(16'd1, 16'd1, 1, 4'h3, FLAW_NONE, 0);
    send_packet();
    long_label_len = 128;
    build_response(16'd1, 16'd1, 1, 4'hC, FLAW_NONE, 0);
    send_packet();
    long_label_len = 0;
    build_response(16'hFFFF, 16'd1, 1, 4'h9, FLAW_NONE, 0);
    send_packet();
  endtask

  // premature ends: first byte, rcode byte, inside the question, and on the
  // last byte of an address that was not the last one
  task automatic test_truncation();
    build_response(16'd1, 16'd1, 1, 4'hA, FLAW_NONE, 0);
    while (pkt_bytes.size() > 1) void'(pkt_bytes.pop_back());
    send_packet();
    build_response(16'd1, 16'd1, 1, 4'hA, FLAW_NONE, 0);
    while (pkt_bytes.size() > 4) void'(pkt_bytes.pop_back());
    send_packet();
    build_response(16'd1, 16'd1, 1, 4'h6, FLAW_NONE, 0);
    while (pkt_bytes.size() > 14) void'(pkt_bytes.pop_back());
    send_packet();
    build_response(16'hFFFF, 16'hFFFF, 2, 4'h1, FLAW_NONE, 0);
    send_packet();
  endtask

  // mostly well-formed responses with random content, the rest damaged or noise
  task automatic test_random_traffic(input int n_bytes);
    int          pick;
    int          n_ans;
    int          stop_at;
    logic [15:0] qd;
    logic [15:0] an_hdr;
    flaw_t       flaw;
    stop_at = bytes_sent + n_bytes;
    while (bytes_sent < stop_at) begin
      pick  = $urandom_range(99);
      n_ans = $urandom_range(3);
      case ($urandom_range(9))
        0:       qd = 16'd0;
        1:       qd = 16'($urandom);
        default: qd = 16'd1;
      endcase
      an_hdr = 16'(n_ans);
      flaw   = FLAW_NONE;
      if (pick >= 60 && pick < 75) begin
        flaw  = flaw_t'($urandom_range(FLAW_RDLEN, FLAW_QTYPE));
        n_ans = $urandom_range(3, 1);
        an_hdr = 16'(n_ans);
      end else if (pick >= 75 && pick < 80)
        an_hdr = 16'(n_ans + $urandom_range(3, 1));
      build_response(qd, an_hdr, n_ans, 4'($urandom_range(15)), flaw,
                     $urandom_range(n_ans - 1 < 0 ? 0 : n_ans - 1));
      if (pick >= 80 && pick < 88) begin
        n_ans = $urandom_range(pkt_bytes.size(), 1);
        while (pkt_bytes.size() > n_ans) void'(pkt_bytes.pop_back());
      end else if (pick >= 88 && pick < 95)
        add_random_bytes($urandom_range(8, 1));
      else if (pick >= 95) begin
        pkt_bytes.delete();
        add_random_bytes($urandom_range(30, 1));
      end
      send_packet();
      if ($urandom_range(24) == 0)
        wait_results_drained();
    end
  endtask

  initial begin
    clear_parse_state();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    send_idle_pct = 34;
    recv_idle_pct = 73;
    test_no_answers();
    test_address_extremes();
    test_field_checks();
    test_name_forms();
    test_truncation();
    test_random_traffic(50);

    send_idle_pct = 73;
    recv_idle_pct = 34;
    test_random_traffic(50);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(50);

    wait_results_drained();
    repeat (4) @(posedge clk);

    $display("covered %0d bytes in %0d responses, %0d result words checked",
             bytes_sent, packets_sent, words_checked);
    $display("idle mixes: sender 34%%/receiver 73%%, then 73%%/34%%, then none");
    if (mismatch_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
